@@ hdl/ifla_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the free-list index allocator.
// No dependencies; used by every module of the block.
package ifla_pkg;

  localparam int POOL_SIZE = 128;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  // head and links hold POOL_SIZE itself as the end-of-list mark
  localparam int HEAD_W    = $clog2(POOL_SIZE + 1);
  localparam int SLOT_W    = 8;
  localparam int GRANT_W   = 7;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_FREE  = 2'd2
  } status_t;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [GRANT_W-1:0] granted_index;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic [HEAD_W-1:0] link;
    logic              in_use;
  } slot_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_entry_t      entry;
  } slot_wr_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_state_t;

endpackage

@@ hdl/ifla_slot_mem.sv @@
`timescale 1ns / 1ps
// Slot table: next link and in-use flag per slot, one read and one write port.
// Depends on ifla_pkg. Unwritten entries read as their reset value.
module ifla_slot_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [ifla_pkg::IDX_W-1:0]  rd_addr,
  input  ifla_pkg::slot_wr_t          wr,
  output ifla_pkg::slot_entry_t       rd_entry
);

  ifla_pkg::slot_entry_t             mem [ifla_pkg::POOL_SIZE];
  logic [ifla_pkg::POOL_SIZE-1:0]    vld_r;
  ifla_pkg::slot_entry_t             mem_rd_r;
  logic                              vld_rd_r;
  logic [ifla_pkg::IDX_W-1:0]        addr_rd_r;
  ifla_pkg::slot_entry_t             dflt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd_en) begin
      mem_rd_r  <= mem[rd_addr];
      addr_rd_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_rd_r <= vld_r[rd_addr];
      end
    end
  end

  // reset value: slot i links to i + 1 and is free
  always_comb begin
    dflt.link   = ifla_pkg::HEAD_W'(addr_rd_r) + ifla_pkg::HEAD_W'(1);
    dflt.in_use = 1'b0;
  end

  assign rd_entry = vld_rd_r ? mem_rd_r : dflt;

endmodule

@@ hdl/index_free_list_allocator_unit.sv @@
`timescale 1ns / 1ps
// Free-list index allocator: LIFO pool of slot indices in a linked slot table.
// An accepted request registers its slot read and moves to the execute state, which registers the result for output.
// A new request waits until the previous one has executed, since the read of the slot
// table must return the head's link first; a stalled result also holds off new requests.
// Reset: head returns to slot 0 and per-entry valid bits clear at once; no clearing pass.
// Depends on ifla_pkg and ifla_slot_mem.
module index_free_list_allocator_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ifla_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ifla_pkg::rsp_t out_data
);

  ifla_pkg::fsm_state_t             state_r, state_nxt;
  logic [ifla_pkg::HEAD_W-1:0]      head_r, head_nxt;
  ifla_pkg::req_t                   req_r;
  logic                             out_valid_r;
  ifla_pkg::rsp_t                   out_data_r, rsp_nxt;
  logic                             accept;
  logic                             rd_en;
  logic [ifla_pkg::IDX_W-1:0]       rd_addr;
  ifla_pkg::slot_entry_t            rd_entry;
  ifla_pkg::slot_wr_t               wr;
  logic                             head_ok;
  logic                             slot_ok;
  logic                             exec;

  assign accept = in_valid && !in_stall;

  ifla_slot_mem u_slot_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .rd_entry (rd_entry)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ifla_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = ifla_pkg::S_EXEC;
        end
      end
      ifla_pkg::S_EXEC: begin
        state_nxt = ifla_pkg::S_IDLE;
      end
      default: state_nxt = ifla_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    exec     = 1'b0;
    unique case (state_r)
      ifla_pkg::S_IDLE: begin
        // output register must be empty or draining before a new transaction
        in_stall = out_valid_r && out_stall;
      end
      ifla_pkg::S_EXEC: begin
        exec = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
        exec     = 1'b0;
      end
    endcase
  end

  assign rd_en   = accept;
  assign rd_addr = (in_data.op == ifla_pkg::OP_FREE) ?
                   in_data.slot_index[ifla_pkg::IDX_W-1:0] :
                   head_r[ifla_pkg::IDX_W-1:0];

  assign head_ok = head_r < ifla_pkg::HEAD_W'(ifla_pkg::POOL_SIZE);
  assign slot_ok = int'(req_r.slot_index) < ifla_pkg::POOL_SIZE;

  // read-modify-write of the addressed slot
  always_comb begin
    head_nxt              = head_r;
    wr.en                 = 1'b0;
    wr.addr               = head_r[ifla_pkg::IDX_W-1:0];
    wr.entry              = rd_entry;
    rsp_nxt.granted_index = '0;
    rsp_nxt.status        = ifla_pkg::ST_OK;
    if (req_r.op == ifla_pkg::OP_ALLOC) begin
      if (head_ok) begin
        rsp_nxt.granted_index = ifla_pkg::GRANT_W'(head_r[ifla_pkg::IDX_W-1:0]);
        head_nxt              = rd_entry.link;
        wr.en                 = exec;
        wr.entry.link         = rd_entry.link;
        wr.entry.in_use       = 1'b1;
      end else begin
        rsp_nxt.status = ifla_pkg::ST_EXHAUSTED;
      end
    end else begin
      wr.addr = req_r.slot_index[ifla_pkg::IDX_W-1:0];
      if (slot_ok && rd_entry.in_use) begin
        head_nxt        = ifla_pkg::HEAD_W'(req_r.slot_index[ifla_pkg::IDX_W-1:0]);
        wr.en           = exec;
        wr.entry.link   = head_r;
        wr.entry.in_use = 1'b0;
      end else begin
        rsp_nxt.status = ifla_pkg::ST_BAD_FREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (exec) begin
      out_data_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ifla_pkg::S_IDLE;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        head_r      <= head_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/ifla_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the free-list index allocator, bound to the top level.
// Depends on ifla_pkg and index_free_list_allocator_unit.
module ifla_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input ifla_pkg::req_t in_data,
  input logic           out_valid,
  input logic           out_stall,
  input ifla_pkg::rsp_t out_data
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // one request in flight: stall right after an accepted transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  // result appears once the request has passed the execute state into the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("result missing two cycles after request");

  // failed requests grant nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ifla_pkg::ST_OK |-> out_data.granted_index == '0)
    else $error("nonzero index on failed request");

  // a free never reports pool exhaustion
  a_free_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == ifla_pkg::OP_FREE |->
      ##2 (out_data.status == ifla_pkg::ST_OK || out_data.status == ifla_pkg::ST_BAD_FREE))
    else $error("free returned exhausted status");

endmodule

bind index_free_list_allocator_unit ifla_checker u_ifla_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
